[sv/mersenne_twister_rng_defines.svh]
// assertion macros used by the random number generator top level
`ifndef MERSENNE_TWISTER_RNG_DEFINES_SVH
`define MERSENNE_TWISTER_RNG_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MTRNG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MTRNG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/mtrng_pkg.sv]
// types, constants and helper functions of the mersenne twister generator
package mtrng_pkg;

   // state table geometry
   localparam int TABLE_WORDS = 624;
   localparam int ADDR_W      = $clog2(TABLE_WORDS + 1);
   localparam int WORD_W      = 32;
   localparam int VALUE_W     = 53;
   localparam int HI_W        = WORD_W - 5;
   localparam int LO_W        = WORD_W - 6;
   localparam int SHIFT_W     = $clog2(WORD_W);

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [SHIFT_W-1:0] shift_type;

   localparam addr_type TABLE_END    = addr_type'(TABLE_WORDS);
   localparam addr_type LAST_ADDR    = addr_type'(TABLE_WORDS - 1);
   localparam addr_type TWIST_OFFSET = addr_type'(397);
   localparam addr_type WRAP_BACK    = addr_type'(TABLE_WORDS - 397);
   localparam addr_type MIX_A_END    = addr_type'(TABLE_WORDS - 1);
   localparam addr_type MIX_B_END    = addr_type'(TABLE_WORDS - 2);

   // seeding and twist constants
   localparam word_type INIT_SEED  = 32'd19650218;
   localparam word_type INIT_MULT  = 32'd1812433253;
   localparam word_type MIX_MULT_A = 32'd1664525;
   localparam word_type MIX_MULT_B = 32'd1566083941;
   localparam word_type UPPER_MASK = 32'h8000_0000;
   localparam word_type TWIST_XOR  = 32'h9908_b0df;
   localparam word_type TEMPER_B   = 32'h9d2c_5680;
   localparam word_type TEMPER_C   = 32'hefc6_0000;

   // request actions
   typedef enum logic [1:0] {
      ACT_SEED   = 2'd0,
      ACT_NEXT   = 2'd1,
      ACT_BELOW  = 2'd2,
      ACT_RAND53 = 2'd3
   } action_type;

   // xor with the top two bits folded down
   function automatic word_type mix30(input word_type w);
      return w ^ (w >> 30);
   endfunction

   // output tempering of one table word
   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // leading zero count in five halving steps, input assumed nonzero
   function automatic shift_type lead_zeros(input word_type v);
      word_type  s;
      shift_type n;
      s = v;
      n = '0;
      if (s[31:16] == 16'd0) begin
         n[4] = 1'b1;
         s = s << 16;
      end
      if (s[31:24] == 8'd0) begin
         n[3] = 1'b1;
         s = s << 8;
      end
      if (s[31:28] == 4'd0) begin
         n[2] = 1'b1;
         s = s << 4;
      end
      if (s[31:30] == 2'd0) begin
         n[1] = 1'b1;
         s = s << 2;
      end
      if (s[31] == 1'b0) begin
         n[0] = 1'b1;
      end
      return n;
   endfunction

endpackage

[sv/mtrng_ram.sv]
// generic one-write two-read ram with registered read data
module mtrng_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   // write port and two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= mem_ff[rd_a_addr];
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

[sv/mersenne_twister_rng.sv]
// mersenne twister random number generator top level
//
// MT19937 generator with single-word seeding, handling one request at a time.
// After reset the block rebuilds the table for seed 0, during which req_stall
// stays high; a seed request rebuilds it the same way. A next request reads
// one table word and tempers it, random53 draws two words, and below draws
// again for each rejected draw. Every 624 words the table is regenerated in
// place first, with a read state and a write state for each table entry on
// the single-write table ram; seeding is paced the same way by the one shared
// 32x32 multiplier. A new request is taken while the previous result still
// waits in the output register.
`include "mersenne_twister_rng_defines.svh"

module mersenne_twister_rng
   import mtrng_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [WORD_W-1:0] req_operand,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output value_type         rsp_value,
   output logic              rsp_bad_bound
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_START,
      ST_INIT_MUL,
      ST_INIT_WR,
      ST_MIX_MUL,
      ST_MIX_WR,
      ST_MIX_WRAP,
      ST_SEED_END,
      ST_REGEN_LOAD,
      ST_REGEN_INIT,
      ST_REGEN_RD,
      ST_REGEN_WR,
      ST_DRAW,
      ST_DRAW_TEMP,
      ST_DRAW_USE,
      ST_RESPOND
   } state_type;

   state_type  state_ff, state_in;
   addr_type   idx_ff, idx_in;
   addr_type   cnt_ff, cnt_in;
   addr_type   rpos_ff, rpos_in;
   logic       phase_ff, phase_in;
   word_type   prev_ff, prev_in;
   word_type   prod_ff, prod_in;
   word_type   cur_ff, cur_in;
   word_type   word_ff, word_in;
   action_type action_ff, action_in;
   word_type   operand_ff, operand_in;
   shift_type  shamt_ff, shamt_in;
   logic       second_ff, second_in;
   logic [HI_W-1:0] hi_ff, hi_in;
   logic       emit_ff, emit_in;
   value_type  res_value_ff, res_value_in;
   logic       res_bad_ff, res_bad_in;
   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_value_ff, rsp_value_in;
   logic       rsp_bad_ff, rsp_bad_in;

   // table ram signals
   logic     wr_en;
   addr_type wr_addr;
   word_type wr_data;
   addr_type rd_a_addr;
   addr_type rd_b_addr;
   word_type rd_a_data;
   word_type rd_b_data;

   // shared datapath terms
   word_type mul_b;
   word_type mul_lo;
   word_type mix_base;
   word_type mix_sum;
   word_type mix_diff;
   word_type twist_y;
   word_type twist_val;
   word_type below_r;

   mtrng_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_WORDS)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a_data),
      .rd_b_addr(rd_b_addr),
      .rd_b_data(rd_b_data)
   );

   // shared multiplier, low half only
   always_comb begin
      if (state_ff == ST_INIT_MUL) begin
         mul_b = INIT_MULT;
      end else if (phase_ff) begin
         mul_b = MIX_MULT_B;
      end else begin
         mul_b = MIX_MULT_A;
      end
   end
   assign mul_lo = word_type'(mix30(prev_ff) * mul_b);

   // seeding mix terms
   assign mix_base = rd_a_data ^ prod_ff;
   assign mix_sum  = mix_base + operand_ff;
   assign mix_diff = mix_base - word_type'(idx_ff);

   // twist of one entry
   assign twist_y   = {cur_ff[WORD_W-1], rd_a_data[WORD_W-2:0]};
   assign twist_val = rd_b_data ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

   // top bits of a draw for below
   assign below_r = word_ff >> shamt_ff;

   // sequencer next state and datapath control
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rpos_in      = rpos_ff;
      phase_in     = phase_ff;
      prev_in      = prev_ff;
      prod_in      = prod_ff;
      cur_in       = cur_ff;
      word_in      = word_ff;
      action_in    = action_ff;
      operand_in   = operand_ff;
      shamt_in     = shamt_ff;
      second_in    = second_ff;
      hi_in        = hi_ff;
      emit_in      = emit_ff;
      res_value_in = res_value_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_bad_in   = rsp_bad_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = prev_ff;
      rd_a_addr    = idx_ff;
      rd_b_addr    = idx_ff;

      // output register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in  = action_type'(req_action);
               operand_in = req_operand;
               shamt_in   = lead_zeros(req_operand);
               second_in  = 1'b0;
               res_value_in = '0;
               res_bad_in   = 1'b0;
               case (action_type'(req_action))
                  ACT_SEED: begin
                     emit_in  = 1'b1;
                     state_in = ST_SEED_START;
                  end
                  ACT_BELOW: begin
                     if (req_operand == '0) begin
                        res_bad_in = 1'b1;
                        state_in   = ST_RESPOND;
                     end else begin
                        state_in = ST_DRAW;
                     end
                  end
                  default: state_in = ST_DRAW;
               endcase
            end
         end

         // first pass: linear fill from the fixed start word
         ST_SEED_START: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = INIT_SEED;
            prev_in  = INIT_SEED;
            idx_in   = addr_type'(1);
            state_in = ST_INIT_MUL;
         end
         ST_INIT_MUL: begin
            prod_in  = mul_lo;
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            wr_en   = 1'b1;
            wr_data = prod_ff + word_type'(idx_ff);
            prev_in = prod_ff + word_type'(idx_ff);
            if (idx_ff == LAST_ADDR) begin
               idx_in   = addr_type'(1);
               cnt_in   = '0;
               phase_in = 1'b0;
               prev_in  = INIT_SEED;
               state_in = ST_MIX_MUL;
            end else begin
               idx_in   = idx_ff + addr_type'(1);
               state_in = ST_INIT_MUL;
            end
         end

         // key mixing passes, phase 0 adds the seed, phase 1 subtracts the index
         ST_MIX_MUL: begin
            rd_a_addr = idx_ff;
            prod_in   = mul_lo;
            state_in  = ST_MIX_WR;
         end
         ST_MIX_WR: begin
            wr_en   = 1'b1;
            wr_data = phase_ff ? mix_diff : mix_sum;
            prev_in = phase_ff ? mix_diff : mix_sum;
            cnt_in  = cnt_ff + addr_type'(1);
            if (idx_ff == LAST_ADDR) begin
               state_in = ST_MIX_WRAP;
            end else begin
               idx_in = idx_ff + addr_type'(1);
               if (cnt_ff == (phase_ff ? MIX_B_END : MIX_A_END)) begin
                  if (phase_ff) begin
                     state_in = ST_SEED_END;
                  end else begin
                     phase_in = 1'b1;
                     cnt_in   = '0;
                     state_in = ST_MIX_MUL;
                  end
               end else begin
                  state_in = ST_MIX_MUL;
               end
            end
         end
         ST_MIX_WRAP: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = prev_ff;
            idx_in   = addr_type'(1);
            state_in = ST_MIX_MUL;
         end
         ST_SEED_END: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = UPPER_MASK;
            rpos_in = TABLE_END;
            emit_in = 1'b0;
            if (emit_ff) begin
               res_value_in = '0;
               res_bad_in   = 1'b0;
               state_in     = ST_RESPOND;
            end else begin
               state_in = ST_IDLE;
            end
         end

         // in-place regeneration, carrying the current entry between steps
         ST_REGEN_LOAD: begin
            rd_a_addr = '0;
            idx_in    = '0;
            state_in  = ST_REGEN_INIT;
         end
         ST_REGEN_INIT: begin
            cur_in   = rd_a_data;
            state_in = ST_REGEN_RD;
         end
         ST_REGEN_RD: begin
            rd_a_addr = (idx_ff == LAST_ADDR) ? '0 : idx_ff + addr_type'(1);
            rd_b_addr = (idx_ff < WRAP_BACK) ? idx_ff + TWIST_OFFSET : idx_ff - WRAP_BACK;
            state_in  = ST_REGEN_WR;
         end
         ST_REGEN_WR: begin
            wr_en   = 1'b1;
            wr_data = twist_val;
            cur_in  = rd_a_data;
            if (idx_ff == LAST_ADDR) begin
               rpos_in  = '0;
               state_in = ST_DRAW;
            end else begin
               idx_in   = idx_ff + addr_type'(1);
               state_in = ST_REGEN_RD;
            end
         end

         // draw one tempered word
         ST_DRAW: begin
            if (rpos_ff == TABLE_END) begin
               state_in = ST_REGEN_LOAD;
            end else begin
               rd_a_addr = rpos_ff;
               state_in  = ST_DRAW_TEMP;
            end
         end
         ST_DRAW_TEMP: begin
            word_in  = temper(rd_a_data);
            rpos_in  = rpos_ff + addr_type'(1);
            state_in = ST_DRAW_USE;
         end
         ST_DRAW_USE: begin
            case (action_ff)
               ACT_BELOW: begin
                  if (below_r < operand_ff) begin
                     res_value_in = value_type'(below_r);
                     state_in     = ST_RESPOND;
                  end else begin
                     state_in = ST_DRAW;
                  end
               end
               ACT_RAND53: begin
                  if (second_ff) begin
                     res_value_in = {hi_ff, word_ff[WORD_W-1:WORD_W-LO_W]};
                     state_in     = ST_RESPOND;
                  end else begin
                     hi_in     = word_ff[WORD_W-1:WORD_W-HI_W];
                     second_in = 1'b1;
                     state_in  = ST_DRAW;
                  end
               end
               default: begin
                  res_value_in = value_type'(word_ff);
                  state_in     = ST_RESPOND;
               end
            endcase
         end

         // hand the result to the output register once it is free
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_bad_in   = res_bad_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      phase_ff     <= phase_in;
      prev_ff      <= prev_in;
      prod_ff      <= prod_in;
      cur_ff       <= cur_in;
      word_ff      <= word_in;
      action_ff    <= action_in;
      shamt_ff     <= shamt_in;
      second_ff    <= second_in;
      hi_ff        <= hi_in;
      res_value_ff <= res_value_in;
      res_bad_ff   <= res_bad_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bad_ff   <= rsp_bad_in;
      if (reset) begin
         state_ff     <= ST_SEED_START;
         rpos_ff      <= TABLE_END;
         operand_ff   <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rpos_ff      <= rpos_in;
         operand_ff   <= operand_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_bad_bound = rsp_bad_ff;

   // checks on the sequencer and result path
   `MTRNG_ASSERT_NOW(a_bad_bound_zero, clock, reset, rsp_valid_ff && rsp_bad_ff,
      rsp_value_ff == '0, "bad bound transaction carries a nonzero value")
   `MTRNG_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall,
      state_ff != ST_IDLE, "accepted transaction did not start work")
   `MTRNG_ASSERT_NOW(a_draw_in_table, clock, reset, state_ff == ST_DRAW_TEMP,
      rpos_ff < TABLE_END, "word drawn past the end of the table")
   `MTRNG_ASSERT_NOW(a_regen_when_spent, clock, reset,
      state_ff == ST_REGEN_RD || state_ff == ST_REGEN_WR,
      rpos_ff == TABLE_END, "regeneration while unread words remain")

endmodule

[tb/sv/mersenne_twister_rng_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench of the mersenne twister random number generator
module mersenne_twister_rng_tb
   import mtrng_pkg::*;
();

   localparam int       MT_WORDS    = 624;
   localparam int       MT_SHIFT    = 397;
   localparam int       CYCLE_LIMIT = 1_000_000;
   localparam int       TAIL_CYCLES = 20;
   localparam word_type SEED_BASE   = 32'd19650218;
   localparam word_type SEED_MULT   = 32'd1812433253;
   localparam word_type KEY_MULT    = 32'd1664525;
   localparam word_type FOLD_MULT   = 32'd1566083941;
   localparam word_type TOP_ONLY    = 32'h8000_0000;
   localparam word_type TWIST_MAGIC = 32'h9908_b0df;
   localparam word_type TEMPER_MSK1 = 32'h9d2c_5680;
   localparam word_type TEMPER_MSK2 = 32'hefc6_0000;

   typedef struct {
      value_type value;
      logic      bad_bound;
   } rng_number_type;

   // generator state copy, expected number queue and checker
   class mt_scoreboard;
      word_type       mt_words [MT_WORDS];
      int unsigned    word_index;
      rng_number_type awaited_numbers [$];
      int unsigned    mismatch_count;
      int unsigned    result_index;

      function new();
         mismatch_count = 0;
         result_index   = 0;
         seed_table(32'd0);
      endfunction

      // single-word key seeding of the whole table
      function void seed_table(input word_type seed);
         word_type    prev;
         int unsigned i;
         mt_words[0] = SEED_BASE;
         for (int k = 1; k < MT_WORDS; k++) begin
            prev = mt_words[k-1];
            mt_words[k] = SEED_MULT * (prev ^ (prev >> 30)) + word_type'(k);
         end
         i = 1;
         for (int n = 0; n < MT_WORDS; n++) begin
            prev = mt_words[i-1];
            mt_words[i] = (mt_words[i] ^ ((prev ^ (prev >> 30)) * KEY_MULT)) + seed;
            i++;
            if (i >= MT_WORDS) begin
               mt_words[0] = mt_words[MT_WORDS-1];
               i = 1;
            end
         end
         for (int n = 0; n < MT_WORDS - 1; n++) begin
            prev = mt_words[i-1];
            mt_words[i] = (mt_words[i] ^ ((prev ^ (prev >> 30)) * FOLD_MULT)) - word_type'(i);
            i++;
            if (i >= MT_WORDS) begin
               mt_words[0] = mt_words[MT_WORDS-1];
               i = 1;
            end
         end
         mt_words[0] = TOP_ONLY;
         word_index  = MT_WORDS;
      endfunction

      // in-place regeneration of all table words
      function void twist_table();
         word_type y;
         word_type t;
         for (int k = 0; k < MT_WORDS; k++) begin
            y = {mt_words[k][31], mt_words[(k + 1) % MT_WORDS][30:0]};
            t = mt_words[(k + MT_SHIFT) % MT_WORDS] ^ (y >> 1);
            if (y[0])
               t = t ^ TWIST_MAGIC;
            mt_words[k] = t;
         end
         word_index = 0;
      endfunction

      // one tempered output word
      function word_type draw_tempered();
         word_type y;
         if (word_index >= MT_WORDS)
            twist_table();
         y = mt_words[word_index];
         word_index++;
         y = y ^ (y >> 11);
         y = y ^ ((y << 7) & TEMPER_MSK1);
         y = y ^ ((y << 15) & TEMPER_MSK2);
         y = y ^ (y >> 18);
         return y;
      endfunction

      // rejection on the top bits until under the bound
      function word_type draw_under(input word_type bound);
         int unsigned bit_len;
         word_type    r;
         bit_len = 0;
         while ((bound >> bit_len) != 0)
            bit_len++;
         do
            r = draw_tempered() >> (32 - bit_len);
         while (r >= bound);
         return r;
      endfunction

      // accepted request: advance the state, queue the expected number
      function void note_request(input action_type act, input word_type operand);
         rng_number_type num;
         word_type       hi_word;
         word_type       lo_word;
         num.value     = '0;
         num.bad_bound = 1'b0;
         case (act)
            ACT_SEED: seed_table(operand);
            ACT_NEXT: num.value = value_type'(draw_tempered());
            ACT_BELOW: begin
               if (operand == 32'd0)
                  num.bad_bound = 1'b1;
               else
                  num.value = value_type'(draw_under(operand));
            end
            default: begin
               hi_word   = draw_tempered();
               lo_word   = draw_tempered();
               num.value = {hi_word[31:5], lo_word[31:6]};
            end
         endcase
         awaited_numbers.insert(awaited_numbers.size(), num);
      endfunction

      task report_mismatch(input string what, input value_type got, input value_type want);
         $display("mismatch at result %0d: %s got %h expected %h",
                  result_index, what, got, want);
         mismatch_count++;
      endtask

      // accepted result against the oldest expected number
      task check_result(input value_type got_value, input logic got_bad);
         rng_number_type want;
         if (awaited_numbers.size() == 0) begin
            report_mismatch("result with no request pending", got_value, '0);
         end else begin
            want = awaited_numbers.pop_front();
            if (got_value !== want.value)
               report_mismatch("value", got_value, want.value);
            if (got_bad !== want.bad_bound)
               report_mismatch("bad_bound", value_type'(got_bad), value_type'(want.bad_bound));
         end
         result_index++;
      endtask
   endclass

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action    = ACT_NEXT;
   logic [WORD_W-1:0] req_operand   = '0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   value_type         rsp_value;
   logic              rsp_bad_bound;

   mt_scoreboard sb;
   int           send_idle_pct  = 25;
   int           recv_stall_pct = 52;
   int unsigned  cycle_count    = 0;

   mersenne_twister_rng i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_operand   (req_operand),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_bad_bound (rsp_bad_bound)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: check accepted transactions, random stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_value, rsp_bad_bound);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // one request transaction, with random idle cycles ahead of it
   task automatic send_request(input action_type act, input word_type operand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_operand <= operand;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      sb.note_request(act, operand);
   endtask

   // hold off until every expected number has come back
   task automatic wait_all_returned();
      req_valid <= 1'b0;
      while (sb.awaited_numbers.size() != 0)
         @(posedge clock);
   endtask

   // runs that open with a seed; about a quarter are long runs of 450 to 650 requests
   task automatic run_random(input int item_total);
      int       done_items;
      int       run_len;
      int       pick;
      word_type operand;
      done_items = 0;
      while (done_items < item_total) begin
         run_len = ($urandom_range(3) == 0) ? $urandom_range(450, 650) : $urandom_range(10, 60);
         pick = $urandom_range(9);
         operand = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hffff_ffff : word_type'($urandom);
         send_request(ACT_SEED, operand);
         done_items++;
         for (int n = 0; n < run_len && done_items < item_total; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               send_request(ACT_NEXT, word_type'($urandom));
            end else if (pick < 72) begin
               pick = $urandom_range(19);
               case (pick)
                  0:       operand = 32'd0;
                  1:       operand = 32'd1;
                  2:       operand = word_type'(1) << $urandom_range(31);
                  3:       operand = (word_type'(1) << $urandom_range(31)) + 32'd1;
                  default: operand = word_type'($urandom) >> $urandom_range(31);
               endcase
               send_request(ACT_BELOW, operand);
            end else begin
               send_request(ACT_RAND53, word_type'($urandom));
            end
            done_items++;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: operand extremes, bound edge cases, reseeding
      send_request(ACT_NEXT,   32'd0);
      send_request(ACT_NEXT,   32'hffff_ffff);
      send_request(ACT_BELOW,  32'd0);
      send_request(ACT_BELOW,  32'd1);
      send_request(ACT_BELOW,  32'd2);
      send_request(ACT_BELOW,  32'd3);
      send_request(ACT_BELOW,  32'h8000_0000);
      send_request(ACT_BELOW,  32'h8000_0001);
      send_request(ACT_BELOW,  32'hffff_ffff);
      send_request(ACT_RAND53, 32'd0);
      send_request(ACT_RAND53, 32'hffff_ffff);
      send_request(ACT_SEED,   32'hffff_ffff);
      send_request(ACT_BELOW,  32'd0);
      send_request(ACT_RAND53, 32'h5555_5555);
      send_request(ACT_NEXT,   32'haaaa_aaaa);
      send_request(ACT_SEED,   32'd0);
      send_request(ACT_NEXT,   32'd0);
      send_request(ACT_SEED,   32'd1);
      send_request(ACT_BELOW,  32'h0001_0000);
      send_request(ACT_NEXT,   32'd0);

      // random phases with different idle patterns
      run_random(600);
      wait_all_returned();
      send_idle_pct  = 52;
      recv_stall_pct = 25;
      run_random(600);
      wait_all_returned();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(530);
      wait_all_returned();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/mtrng_pkg.sv
sv/mtrng_ram.sv
sv/mersenne_twister_rng.sv
tb/sv/mersenne_twister_rng_tb.sv
